@@ design/slcpr_pkg.sv @@
package slcpr_pkg;

    localparam int BUF_WORDS = 1024;
    localparam int ADDR_W = $clog2(BUF_WORDS);
    localparam int POS_W = ADDR_W + 2;
    localparam int POS_LIMIT = BUF_WORDS * 4;
    localparam int LANES = 4;

    localparam int OP_W = 2;
    localparam int BYTE_W = 8;
    localparam int INDEX_W = 10;
    localparam int WORD_W = 32;
    localparam int EVENT_W = 3;
    localparam int TIMEOUT_W = 16;
    localparam int CRC_W = 16;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 72;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [TIMEOUT_W-1:0] COUNT_MAX = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_PRESET = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
    localparam logic [BYTE_W-1:0] SYNC_EVEN = 8'h55;
    localparam logic [BYTE_W-1:0] SYNC_ODD = 8'hAA;
    localparam logic [CRC_W:0] LEN_TRAILER = 17'd2;

    typedef enum logic [OP_W-1:0] {
        OP_BYTE    = 2'd0,
        OP_TICK    = 2'd1,
        OP_RELEASE = 2'd2,
        OP_READ    = 2'd3
    } op_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE          = 3'd0,
        EV_GOOD          = 3'd1,
        EV_CRC_FAIL      = 3'd2,
        EV_LEN_TOO_LARGE = 3'd3,
        EV_SYNC_MISMATCH = 3'd4,
        EV_REFUSED       = 3'd5
    } event_t;

    typedef struct packed {
        logic              wr_en;
        logic [1:0]        wr_lane;
        logic [ADDR_W-1:0] wr_addr;
        logic [BYTE_W-1:0] wr_byte;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

    typedef struct packed {
        event_t            ev;
        logic              ready;
        logic [WORD_W-1:0] pkt_time;
        logic              rd_zero;
    } res_t;

    function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] acc,
                                                    input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = acc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] sync_byte(input logic [1:0] lane);
        return lane[0] ? SYNC_ODD : SYNC_EVEN;
    endfunction

endpackage

@@ design/slcpr_ram.sv @@
module slcpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/slcpr_buffer.sv @@
module slcpr_buffer (
    input  logic                     aclk,
    input  slcpr_pkg::mem_req_t      req,
    output logic [slcpr_pkg::WORD_W-1:0] rd_word
);
    import slcpr_pkg::*;

    // Each byte lane has its own RAM, so a byte write never needs the old word.
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        logic lane_we;

        assign lane_we = req.wr_en && (req.wr_lane == 2'(g));

        slcpr_ram #(
            .WIDTH(BYTE_W),
            .DEPTH(BUF_WORDS)
        ) u_lane_ram (
            .aclk (aclk),
            .we   (lane_we),
            .waddr(req.wr_addr),
            .wdata(req.wr_byte),
            .re   (req.rd_en),
            .raddr(req.rd_addr),
            .rdata(rd_word[g*BYTE_W +: BYTE_W])
        );
    end

endmodule

@@ design/slcpr_ctrl.sv @@
module slcpr_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            step,
    input  slcpr_pkg::op_t                  op,
    input  logic [slcpr_pkg::BYTE_W-1:0]    rx_byte,
    input  logic [slcpr_pkg::INDEX_W-1:0]   word_index,
    input  logic [slcpr_pkg::WORD_W-1:0]    now_ms,
    input  logic                            cfg_wr_en,
    input  logic [slcpr_pkg::TIMEOUT_W-1:0] cfg_wr_data,
    output slcpr_pkg::mem_req_t             mem_req,
    output slcpr_pkg::res_t                 res
);
    import slcpr_pkg::*;

    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [CRC_W-1:0]     crc_reg, crc_next;
    logic [TIMEOUT_W-1:0] idle_reg, idle_next;
    logic                 ready_reg, ready_next;
    logic [WORD_W-1:0]    time_reg, time_next;
    logic [TIMEOUT_W-1:0] timeout_reg;
    // Shadow of buffer word 1: bytes 4-7 of the current frame.
    logic [CRC_W-1:0]     crc_exp_reg, crc_exp_next;
    logic [CRC_W-1:0]     len_reg, len_next;

    logic [POS_W-1:0]     pos;
    logic [POS_W:0]       pos_inc;
    logic [17:0]          got;
    logic [17:0]          need;
    logic [CRC_W-1:0]     crc_new;
    logic [TIMEOUT_W-1:0] idle_inc;
    logic                 rd_in_range;
    event_t               ev;

    assign pos = ({{(32-POS_W){1'b0}}, pos_reg} >= 32'(POS_LIMIT)) ? '0 : pos_reg;
    assign pos_inc = {1'b0, pos} + 1'b1;
    assign got = 18'(pos_inc >> 2);
    assign need = {1'b0, {1'b0, len_reg} + LEN_TRAILER};
    assign crc_new = crc16_byte(crc_reg, rx_byte);
    assign idle_inc = (idle_reg == COUNT_MAX) ? COUNT_MAX : idle_reg + 1'b1;
    assign rd_in_range = (32'(word_index) < 32'(BUF_WORDS));

    always_comb begin
        pos_next = pos_reg;
        crc_next = crc_reg;
        idle_next = idle_reg;
        ready_next = ready_reg;
        time_next = time_reg;
        crc_exp_next = crc_exp_reg;
        len_next = len_reg;
        ev = EV_NONE;
        unique case (op)
            OP_BYTE: begin
                if (ready_reg) begin
                    ev = EV_REFUSED;
                end else begin
                    pos_next = pos_inc[POS_W-1:0];
                    idle_next = '0;
                    if (pos < POS_W'(4)) begin
                        if (rx_byte != sync_byte(pos[1:0])) begin
                            pos_next = '0;
                            ev = EV_SYNC_MISMATCH;
                        end else if (pos == '0) begin
                            time_next = now_ms;
                        end
                    end else if (pos < POS_W'(8)) begin
                        unique case (pos[1:0])
                            2'd0: crc_exp_next[7:0] = rx_byte;
                            2'd1: crc_exp_next[15:8] = rx_byte;
                            2'd2: len_next[7:0] = rx_byte;
                            default: begin
                                len_next[15:8] = rx_byte;
                                crc_next = CRC_PRESET;
                            end
                        endcase
                    end else begin
                        crc_next = crc_new;
                        if (need >= 18'(BUF_WORDS)) begin
                            pos_next = '0;
                            ev = EV_LEN_TOO_LARGE;
                        end else if (got >= need) begin
                            pos_next = '0;
                            if (crc_new == crc_exp_reg) begin
                                ready_next = 1'b1;
                                ev = EV_GOOD;
                            end else begin
                                ev = EV_CRC_FAIL;
                            end
                        end
                    end
                end
            end
            OP_TICK: begin
                idle_next = idle_inc;
                if (idle_inc >= timeout_reg) begin
                    pos_next = '0;
                    idle_next = '0;
                end
            end
            OP_RELEASE: begin
                ready_next = 1'b0;
            end
            OP_READ: begin
            end
        endcase
    end

    always_comb begin
        mem_req.wr_en = step && (op == OP_BYTE) && !ready_reg;
        mem_req.wr_lane = pos[1:0];
        mem_req.wr_addr = pos[POS_W-1:2];
        mem_req.wr_byte = rx_byte;
        mem_req.rd_en = step && (op == OP_READ) && rd_in_range;
        mem_req.rd_addr = ADDR_W'(word_index);
        res.ev = ev;
        res.ready = ready_next;
        res.pkt_time = time_next;
        res.rd_zero = !((op == OP_READ) && rd_in_range);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            crc_reg <= CRC_PRESET;
            idle_reg <= '0;
            ready_reg <= 1'b0;
            time_reg <= '0;
            timeout_reg <= TIMEOUT_RESET;
        end else begin
            if (step) begin
                pos_reg <= pos_next;
                crc_reg <= crc_next;
                idle_reg <= idle_next;
                ready_reg <= ready_next;
                time_reg <= time_next;
            end
            if (cfg_wr_en) begin
                timeout_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            crc_exp_reg <= crc_exp_next;
            len_reg <= len_next;
        end
    end

endmodule

@@ design/sync_length_crc_packet_receiver_top.sv @@
// Byte-serial packet receiver with sync word, length and CRC-16 check.
// The slave channel carries one request per beat: s_tuser holds the operation
// (received byte, millisecond tick, release packet, read buffer word) and
// s_tdata its operands. The master channel returns exactly one result per
// request, in order: an event code, the ready flag, a buffer word for reads
// and the time captured at the start of the last packet.
// The idle timeout in milliseconds is written through cfg_wr_en/cfg_wr_data; write it only
// while no request is in flight, which the user must ensure: the block does not enforce it.
// Throughput is one request per clock cycle while the output is not stalled.
// A result passes the state update and the registered read of the frame buffer
// RAM, then the output register, before it is offered.
// All other per-byte work (sync compare, CRC byte step, length check) is done
// in the accept cycle, so bytes may follow each other without gaps.
// Reset clears the byte position, the ready flag, the idle count and the
// captured time, and loads a timeout of 1000 ms; the buffer RAM keeps its
// contents and a word must be written before it is read.
// When m_tready is low, one more request is taken into the internal stage
// behind the output register, after which s_tready drops until the output
// moves.
module sync_length_crc_packet_receiver_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // rx_byte[7:0], word_index[17:8], now_ms[49:18], zero fill
    input  logic [slcpr_pkg::S_TDATA_W-1:0]  s_tdata,
    // op[1:0]
    input  logic [slcpr_pkg::OP_W-1:0]       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // event_res[2:0], packet_ready[3], read_data[35:4], packet_time[67:36], zero fill
    output logic [slcpr_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                             cfg_wr_en,
    input  logic [slcpr_pkg::TIMEOUT_W-1:0]  cfg_wr_data
);
    import slcpr_pkg::*;

    logic              accept;
    logic              p_move;
    mem_req_t          mem_req;
    res_t              res;
    logic [WORD_W-1:0] rd_word;
    logic [WORD_W-1:0] rd_data;
    op_t               op;

    logic              p_valid_reg, p_valid_next;
    res_t              p_res_reg;
    logic              m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    assign op = op_t'(s_tuser);
    assign s_tready = !p_valid_reg || !m_valid_reg || m_tready;
    assign accept = s_tvalid && s_tready;
    assign p_move = p_valid_reg && (!m_valid_reg || m_tready);

    slcpr_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (accept),
        .op         (op),
        .rx_byte    (s_tdata[7:0]),
        .word_index (s_tdata[17:8]),
        .now_ms     (s_tdata[49:18]),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .mem_req    (mem_req),
        .res        (res)
    );

    slcpr_buffer u_buffer (
        .aclk   (aclk),
        .req    (mem_req),
        .rd_word(rd_word)
    );

    assign rd_data = p_res_reg.rd_zero ? '0 : rd_word;

    always_comb begin
        p_valid_next = p_valid_reg;
        if (accept) begin
            p_valid_next = 1'b1;
        end else if (p_move) begin
            p_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (p_move) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
        m_data_next = {4'b0, p_res_reg.pkt_time, rd_data, p_res_reg.ready, p_res_reg.ev};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            p_valid_reg <= p_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p_res_reg <= res;
        end
        if (p_move) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (p_valid_reg && m_valid_reg))
        else $error("input stalled while a stage is free");

    a_accept_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> p_valid_reg)
        else $error("accepted request did not reach the pending stage");

    a_good_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && ((m_tdata[2:0] == EV_GOOD) || (m_tdata[2:0] == EV_REFUSED)))
            |-> m_tdata[3])
        else $error("good or refused event without ready flag");

    a_zero_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (p_valid_reg && p_res_reg.rd_zero) |-> (rd_data == '0))
        else $error("read data not zero for a non-read request");

endmodule
